@@ design/dual_sample_fifo_stereo_mixer_defines.svh @@
`ifndef DUAL_SAMPLE_FIFO_STEREO_MIXER_DEFINES_SVH
`define DUAL_SAMPLE_FIFO_STEREO_MIXER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/sdf_pkg.sv @@
package sdf_pkg;

  localparam int FIFO_SLOTS_DEF = 32;
  localparam int PERIOD_DEF     = 512;

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_FULL_VOLUME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_FULL_VOLUME  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROUTING      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROUTING      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_A_TIMER_SELECT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_B_TIMER_SELECT = 3'd6;

  typedef struct packed {
    logic [1:0] func;
    logic       fifo_select;
    logic [7:0] sample_byte;
    logic       reset_a;
    logic       reset_b;
    logic [1:0] timer_overflow;
  } item_t;

  typedef struct packed {
    logic               refill_a;
    logic               refill_b;
    logic               frame_valid;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [5:0]         level_a;
    logic [5:0]         level_b;
  } result_t;

  typedef struct packed {
    logic       master_enable;
    logic       a_full_volume;
    logic       b_full_volume;
    logic [1:0] a_routing;
    logic [1:0] b_routing;
    logic       a_timer_select;
    logic       b_timer_select;
  } cfg_t;

  typedef struct packed {
    logic       push;
    logic       clear;
    logic       service;
    logic [7:0] data;
  } chan_ctl_t;

endpackage

@@ design/sdf_ram.sv @@
module sdf_ram #(
  parameter int DEPTH = sdf_pkg::FIFO_SLOTS_DEF,
  parameter int AW    = $clog2(sdf_pkg::FIFO_SLOTS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/sdf_chan.sv @@
`include "dual_sample_fifo_stereo_mixer_defines.svh"

module sdf_chan #(
  parameter int SLOTS = sdf_pkg::FIFO_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sdf_pkg::chan_ctl_t ctl,
  output logic [5:0]        level_out,
  output logic [7:0]        latch_out,
  output logic              refill
);

  localparam int PW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);

  logic [PW-1:0] rp, rp_next, wp, wp_next;
  logic [LW-1:0] level, level_next;
  logic [7:0]    latch, latch_next;
  logic [7:0]    rd_data;
  logic          full;
  logic          we;
  logic [LW+5:0] level_ext;

  function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
    return (p == PW'(SLOTS - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full = (level == LW'(SLOTS));
  assign we   = ctl.push && !full;

  sdf_ram #(.DEPTH(SLOTS), .AW(PW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (ctl.data),
    .raddr (rp),
    .rdata (rd_data)
  );

  always_comb begin
    rp_next    = rp;
    wp_next    = wp;
    level_next = level;
    latch_next = latch;
    refill     = 1'b0;
    if (ctl.clear) begin
      rp_next    = '0;
      wp_next    = '0;
      level_next = '0;
      latch_next = '0;
    end else if (ctl.push) begin
      if (!full) begin
        wp_next    = step(wp);
        level_next = level + LW'(1);
      end
    end else if (ctl.service) begin
      if (level != '0) begin
        latch_next = rd_data;
        rp_next    = step(rp);
        level_next = level - LW'(1);
      end
      refill = (level_next <= LW'(SLOTS / 2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp    <= '0;
      wp    <= '0;
      level <= '0;
      latch <= '0;
    end else begin
      rp    <= rp_next;
      wp    <= wp_next;
      level <= level_next;
      latch <= latch_next;
    end
  end

  assign level_ext = {6'b0, level_next};
  assign level_out = level_ext[5:0];
  assign latch_out = latch_next;

  `SDF_ASSERT_NOW(a_level_bound, 1'b1, level <= LW'(SLOTS), "fifo level above depth")
  `SDF_ASSERT_NOW(a_empty_ptrs, level == '0, rp == wp, "empty fifo with split pointers")

endmodule

@@ design/sdf_mix.sv @@
module sdf_mix (
  input  sdf_pkg::cfg_t      cfg,
  input  logic [7:0]         latch_a,
  input  logic [7:0]         latch_b,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample
);

  logic signed [7:0]  a_val, b_val;
  logic signed [9:0]  a_ext, b_ext, left_sum, right_sum;
  logic signed [16:0] left_prod, right_prod;

  function automatic logic signed [15:0] clamp16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  always_comb begin
    a_val = cfg.a_full_volume ? $signed(latch_a) : ($signed(latch_a) >>> 1);
    b_val = cfg.b_full_volume ? $signed(latch_b) : ($signed(latch_b) >>> 1);
    a_ext = $signed({{2{a_val[7]}}, a_val});
    b_ext = $signed({{2{b_val[7]}}, b_val});
    left_sum  = (cfg.a_routing[1] ? a_ext : 10'sd0) + (cfg.b_routing[1] ? b_ext : 10'sd0);
    right_sum = (cfg.a_routing[0] ? a_ext : 10'sd0) + (cfg.b_routing[0] ? b_ext : 10'sd0);
    left_prod  = $signed({left_sum, 7'b0});
    right_prod = $signed({right_sum, 7'b0});
    left_sample  = clamp16(left_prod);
    right_sample = clamp16(right_prod);
  end

endmodule

@@ design/dual_sample_fifo_stereo_mixer.sv @@
// Two-channel sample FIFO mixer. The edge that accepts an item also
// fetches both FIFO heads from their single-port-read memories, and the
// edge that leaves S_EXEC applies the push, reset event or tick and loads
// the result register, so item_stall is high for one cycle per item, and
// longer while a finished result is held by result_stall. FIFO memories are
// not cleared after reset; a reset event rewinds pointers and levels and
// zeroes the output latch. Configuration writes are always taken (cfg_ready is tied high).
`include "dual_sample_fifo_stereo_mixer_defines.svh"

module dual_sample_fifo_stereo_mixer #(
  parameter int FIFO_SLOTS = sdf_pkg::FIFO_SLOTS_DEF,
  parameter int PERIOD     = sdf_pkg::PERIOD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  sdf_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output sdf_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(PERIOD + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state;
  sdf_pkg::item_t     item_q;
  sdf_pkg::cfg_t      cfg;
  sdf_pkg::chan_ctl_t ctl_a, ctl_b;
  logic [CW-1:0]      period_cnt, period_inc;
  logic               go, tick, frame;
  logic [5:0]         level_a, level_b;
  logic [7:0]         latch_a, latch_b;
  logic               refill_a, refill_b;
  logic signed [15:0] mix_left, mix_right;
  logic               audible;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign go         = (state == S_EXEC) && (!result_valid || !result_stall);
  assign tick       = go && (item_q.func == sdf_pkg::FUNC_TICK);
  assign period_inc = period_cnt + CW'(1);
  assign frame      = tick && (period_inc == CW'(PERIOD));
  assign audible    = frame && cfg.master_enable;

  always_comb begin
    ctl_a.data    = item_q.sample_byte;
    ctl_b.data    = item_q.sample_byte;
    ctl_a.push    = go && (item_q.func == sdf_pkg::FUNC_PUSH) && !item_q.fifo_select;
    ctl_b.push    = go && (item_q.func == sdf_pkg::FUNC_PUSH) && item_q.fifo_select;
    ctl_a.clear   = go && (item_q.func == sdf_pkg::FUNC_CLEAR) && item_q.reset_a;
    ctl_b.clear   = go && (item_q.func == sdf_pkg::FUNC_CLEAR) && item_q.reset_b;
    ctl_a.service = tick && cfg.master_enable
                    && item_q.timer_overflow[cfg.a_timer_select];
    ctl_b.service = tick && cfg.master_enable
                    && item_q.timer_overflow[cfg.b_timer_select];
  end

  sdf_chan #(.SLOTS(FIFO_SLOTS)) u_chan_a (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_a),
    .level_out (level_a),
    .latch_out (latch_a),
    .refill    (refill_a)
  );

  sdf_chan #(.SLOTS(FIFO_SLOTS)) u_chan_b (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_b),
    .level_out (level_b),
    .latch_out (latch_b),
    .refill    (refill_b)
  );

  sdf_mix u_mix (
    .cfg          (cfg),
    .latch_a      (latch_a),
    .latch_b      (latch_b),
    .left_sample  (mix_left),
    .right_sample (mix_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sdf_pkg::CFG_MASTER_ENABLE:  cfg.master_enable  <= cfg_data[0];
        sdf_pkg::CFG_A_FULL_VOLUME:  cfg.a_full_volume  <= cfg_data[0];
        sdf_pkg::CFG_B_FULL_VOLUME:  cfg.b_full_volume  <= cfg_data[0];
        sdf_pkg::CFG_A_ROUTING:      cfg.a_routing      <= cfg_data;
        sdf_pkg::CFG_B_ROUTING:      cfg.b_routing      <= cfg_data;
        sdf_pkg::CFG_A_TIMER_SELECT: cfg.a_timer_select <= cfg_data[0];
        sdf_pkg::CFG_B_TIMER_SELECT: cfg.b_timer_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_cnt <= '0;
    end else if (tick) begin
      period_cnt <= frame ? '0 : period_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result.refill_a     <= refill_a;
      result.refill_b     <= refill_b;
      result.frame_valid  <= frame;
      result.left_sample  <= audible ? mix_left : 16'sd0;
      result.right_sample <= audible ? mix_right : 16'sd0;
      result.level_a      <= level_a;
      result.level_b      <= level_b;
    end
  end

  `SDF_ASSERT_NOW(a_period_bound, 1'b1, period_cnt < CW'(PERIOD), "period counter overran")
  `SDF_ASSERT_NEXT(a_go_done, go, state == S_IDLE && result_valid, "result not loaded")

endmodule

@@ verif/sdf_mix_checker.sv @@
module sdf_mix_checker
  import sdf_pkg::*;
#(
  parameter int FIFO_SLOTS = FIFO_SLOTS_DEF,
  parameter int PERIOD     = PERIOD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    outstanding,
  output int                    errors
);

  cfg_t       regs;
  logic [7:0] fifo_mem [2][FIFO_SLOTS];
  int         rd_ptr [2];
  int         wr_ptr [2];
  int         fill [2];
  logic [7:0] latch [2];
  int         tick_count;
  result_t    expected_mix [$];
  int         mismatch_count;

  assign errors = mismatch_count;

  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_MASTER_ENABLE:  regs.master_enable  = val[0];
      CFG_A_FULL_VOLUME:  regs.a_full_volume  = val[0];
      CFG_B_FULL_VOLUME:  regs.b_full_volume  = val[0];
      CFG_A_ROUTING:      regs.a_routing      = val;
      CFG_B_ROUTING:      regs.b_routing      = val;
      CFG_A_TIMER_SELECT: regs.a_timer_select = val[0];
      CFG_B_TIMER_SELECT: regs.b_timer_select = val[0];
      default: ;
    endcase
  endfunction

  // pop into the latch if this channel's timer fired; report refill need
  function automatic logic service_chan(int ch, logic sel, logic [1:0] ovf);
    if (!ovf[sel]) return 1'b0;
    if (fill[ch] != 0) begin
      latch[ch] = fifo_mem[ch][rd_ptr[ch]];
      rd_ptr[ch] = (rd_ptr[ch] + 1) % FIFO_SLOTS;
      fill[ch]--;
    end
    return fill[ch] <= FIFO_SLOTS / 2;
  endfunction

  function automatic int scaled(int ch, logic full_vol);
    int s;
    s = int'($signed(latch[ch]));
    if (!full_vol) s = s >>> 1;
    return s;
  endfunction

  function automatic logic signed [15:0] clamp_mix(int v);
    int p;
    p = v * 128;
    if (p > 32767) p = 32767;
    else if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  function automatic result_t mix_step(item_t it);
    result_t r;
    int      ch;
    int      a;
    int      b;
    int      l;
    int      rt;
    r = '0;
    l = 0;
    rt = 0;
    case (it.func)
      FUNC_PUSH: begin
        ch = int'(it.fifo_select);
        if (fill[ch] < FIFO_SLOTS) begin
          fifo_mem[ch][wr_ptr[ch]] = it.sample_byte;
          wr_ptr[ch] = (wr_ptr[ch] + 1) % FIFO_SLOTS;
          fill[ch]++;
        end
      end
      FUNC_CLEAR: begin
        for (int c = 0; c < 2; c++) begin
          if (c == 0 ? it.reset_a : it.reset_b) begin
            rd_ptr[c] = 0;
            wr_ptr[c] = 0;
            fill[c] = 0;
            latch[c] = '0;
          end
        end
      end
      FUNC_TICK: begin
        if (regs.master_enable) begin
          r.refill_a = service_chan(0, regs.a_timer_select, it.timer_overflow);
          r.refill_b = service_chan(1, regs.b_timer_select, it.timer_overflow);
        end
        tick_count++;
        if (tick_count >= PERIOD) begin
          tick_count = 0;
          r.frame_valid = 1'b1;
          if (regs.master_enable) begin
            a = scaled(0, regs.a_full_volume);
            b = scaled(1, regs.b_full_volume);
            if (regs.a_routing[1]) l += a;
            if (regs.a_routing[0]) rt += a;
            if (regs.b_routing[1]) l += b;
            if (regs.b_routing[0]) rt += b;
          end
          r.left_sample = clamp_mix(l);
          r.right_sample = clamp_mix(rt);
        end
      end
      default: ;
    endcase
    r.level_a = 6'(fill[0]);
    r.level_b = 6'(fill[1]);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      if (mismatch_count < 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs = '0;
      for (int c = 0; c < 2; c++) begin
        rd_ptr[c] = 0;
        wr_ptr[c] = 0;
        fill[c] = 0;
        latch[c] = '0;
      end
      tick_count = 0;
      expected_mix.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) set_reg(cfg_index, cfg_data);
      if (item_valid && !item_stall) expected_mix.push_back(mix_step(item));
      if (result_valid && !result_stall) begin
        if (expected_mix.size() == 0) begin
          if (mismatch_count < 10) $display("%0t: result with no item pending", $time);
          mismatch_count++;
        end else begin
          want = expected_mix.pop_front();
          check_field("refill_a", int'(want.refill_a), int'(result.refill_a));
          check_field("refill_b", int'(want.refill_b), int'(result.refill_b));
          check_field("frame_valid", int'(want.frame_valid), int'(result.frame_valid));
          check_field("left_sample", int'(want.left_sample), int'(result.left_sample));
          check_field("right_sample", int'(want.right_sample), int'(result.right_sample));
          check_field("level_a", int'(want.level_a), int'(result.level_a));
          check_field("level_b", int'(want.level_b), int'(result.level_b));
        end
      end
    end
    outstanding <= expected_mix.size();
  end

endmodule

@@ verif/tb_dual_sample_fifo_stereo_mixer.sv @@
module tb_dual_sample_fifo_stereo_mixer;
  import sdf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 40;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_BURSTS} stall_style_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    outstanding;
  int                    errors;
  int                    ticks_sent = 0;
  int                    burst_left = 0;
  int                    idle_cycles = 0;
  stall_style_t          stall_mode = STALL_NONE;
  int                    stall_left = 0;
  int                    mode_left = 0;

  always #6 clk = ~clk;

  dual_sample_fifo_stereo_mixer dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  sdf_mix_checker u_checker (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .outstanding(outstanding),
    .errors(errors)
  );

  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left <= $urandom_range(50, 400);
      stall_mode <= stall_style_t'($urandom_range(0, 2));
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE: result_stall <= 1'b0;
      STALL_RANDOM: result_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_left == 0) begin
          result_stall <= ~result_stall;
          stall_left <= $urandom_range(1, 20);
        end else begin
          stall_left <= stall_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** dual_sample_fifo_stereo_mixer: FAILED **");
        $finish;
      end
    end
  end

  function automatic item_t any_item();
    return item_t'($bits(item_t)'($urandom));
  endfunction

  function automatic item_t push_item(logic ch, logic [7:0] smp);
    item_t it;
    it = any_item();
    it.func = FUNC_PUSH;
    it.fifo_select = ch;
    it.sample_byte = smp;
    return it;
  endfunction

  function automatic item_t tick_item(logic [1:0] ovf);
    item_t it;
    it = any_item();
    it.func = FUNC_TICK;
    it.timer_overflow = ovf;
    return it;
  endfunction

  function automatic item_t clear_item(logic ra, logic rb);
    item_t it;
    it = any_item();
    it.func = FUNC_CLEAR;
    it.reset_a = ra;
    it.reset_b = rb;
    return it;
  endfunction

  task automatic send_item(item_t it);
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (it.func == FUNC_TICK) ticks_sent++;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // valid stays high across back-to-back writes; caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(cfg_t s);
    wait_idle();
    write_reg(CFG_MASTER_ENABLE, {1'($urandom_range(0, 1)), s.master_enable});
    write_reg(CFG_A_FULL_VOLUME, {1'($urandom_range(0, 1)), s.a_full_volume});
    write_reg(CFG_B_FULL_VOLUME, {1'($urandom_range(0, 1)), s.b_full_volume});
    write_reg(CFG_A_ROUTING, s.a_routing);
    write_reg(CFG_B_ROUTING, s.b_routing);
    write_reg(CFG_A_TIMER_SELECT, {1'($urandom_range(0, 1)), s.a_timer_select});
    write_reg(CFG_B_TIMER_SELECT, {1'($urandom_range(0, 1)), s.b_timer_select});
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, 2'($urandom_range(0, 3)));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic to_frame);
    int  n;
    int  k;
    int  done;
    logic ch;
    done = 0;
    while (done < PHASE_ITEMS) begin
      k = $urandom_range(0, 9);
      if (k <= 2) begin
        ch = 1'($urandom_range(0, 1));
        n = $urandom_range(4, FIFO_SLOTS_DEF + 6);
        repeat (n) send_item(push_item(ch, 8'($urandom)));
      end else if (k <= 5) begin
        n = $urandom_range(1, FIFO_SLOTS_DEF + 4);
        repeat (n) send_item(tick_item(2'($urandom)));
      end else if (k == 6) begin
        n = 1;
        send_item(clear_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end else if (k <= 8) begin
        n = $urandom_range(4, 16);
        repeat (n) begin
          if ($urandom_range(0, 1))
            send_item(push_item(1'($urandom_range(0, 1)), 8'($urandom)));
          else send_item(tick_item(2'($urandom)));
        end
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(any_item());
      end
      done += n;
    end
    // run ticks up to the next frame boundary, popping now and then
    if (to_frame) begin
      do begin
        k = $urandom_range(0, 15);
        if (k == 0) send_item(push_item(1'($urandom_range(0, 1)), 8'($urandom)));
        else if (k == 1) send_item(tick_item(2'($urandom)));
        else send_item(tick_item(2'b00));
      end while (ticks_sent % PERIOD_DEF != 0);
    end
  endtask

  initial begin
    cfg_t s;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // master still off from reset
    send_item(tick_item(2'b11));
    send_item(push_item(1'b0, 8'h7F));

    s = '{1'b1, 1'b0, 1'b1, 2'd2, 2'd1, 1'b0, 1'b1};
    apply_setting(s);
    send_item(push_item(1'b0, 8'h80));
    send_item(push_item(1'b1, 8'h00));
    send_item(push_item(1'b1, 8'hFF));
    send_item(push_item(1'b1, 8'h81));
    send_item(tick_item(2'b00));
    send_item(tick_item(2'b01));
    send_item(tick_item(2'b10));
    send_item(tick_item(2'b11));
    send_item(tick_item(2'b11));  // A runs dry, latch holds
    send_item(tick_item(2'b11));
    send_item(clear_item(1'b0, 1'b0));
    send_item(push_item(1'b0, 8'h55));
    send_item(clear_item(1'b1, 1'b0));
    send_item(push_item(1'b1, 8'h11));
    send_item(clear_item(1'b0, 1'b1));
    send_item(push_item(1'b0, 8'h01));
    send_item(push_item(1'b1, 8'h02));
    send_item(clear_item(1'b1, 1'b1));
    begin
      item_t odd;
      odd = any_item();
      odd.func = FUNC_UNUSED;
      send_item(odd);
    end
    send_item(tick_item(2'b11));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: s = '1;
        1: begin
          s = '0;
          s.master_enable = 1'b1;
        end
        2: begin
          s = '1;
          s.master_enable = 1'b0;
        end
        default: begin
          s = cfg_t'($bits(cfg_t)'($urandom));
          s.master_enable = ($urandom_range(0, 5) != 0);
        end
      endcase
      if (p == PHASES - 1) s.master_enable = 1'b1;
      apply_setting(s);
      run_phase(p == PHASES - 1);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("** dual_sample_fifo_stereo_mixer: PASSED **");
    end else begin
      $display("** dual_sample_fifo_stereo_mixer: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/sdf_pkg.sv
design/sdf_ram.sv
design/sdf_chan.sv
design/sdf_mix.sv
design/dual_sample_fifo_stereo_mixer.sv
verif/sdf_mix_checker.sv
verif/tb_dual_sample_fifo_stereo_mixer.sv
